// File: rtl/awb_pkg.sv
// Package for the affine warp bilinear core: constants, register indexes, widths.
// No dependencies.
`default_nettype none
package awb_pkg;
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int COORD_BITS     = 12;
  localparam int COEF_W         = 17;
  localparam int OFFS_W         = 24;
  localparam int DIM_W          = 10;
  localparam int IDX_W          = 3;
  localparam int CFG_W          = 24;
  localparam int POS_W          = 11;
  // Mapped coordinate: 17x12 products, two of them plus a 24-bit offset.
  localparam int MAP_W          = 32;

  localparam logic [IDX_W-1:0] REG_COEF_UU  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_UR  = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_VC  = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_VR  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET_U = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET_V = 3'd5;
  localparam logic [IDX_W-1:0] REG_SRC_W    = 3'd6;
  localparam logic [IDX_W-1:0] REG_SRC_H    = 3'd7;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;
endpackage
`default_nettype wire

// File: rtl/awb_bank.sv
// One parity bank of the source frame: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module awb_bank #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, held while stalled
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/affine_warp_bilinear_core.sv
// Affine warp core, 8-bit gray. Each item is either a source pixel write or an
// output pixel request; a request gives one result, a write none. One item per
// clock is accepted while the output is not stalled; a request result passes the
// product, sum, read, horizontal, vertical and output stages. The rate is set by
// four parity-banked frame memories (even/odd column times even/odd row) that
// serve all four bilinear neighbours in the same read. A write travels down the
// pipe and lands at the read stage, so it is seen by every later request and by
// no earlier one. Frame contents are undefined until written.
// Depends on awb_pkg and awb_bank.
`default_nettype none
module affine_warp_bilinear_core #(
  parameter int MAX_WIDTH  = awb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = awb_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = awb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [awb_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [awb_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       command,
  input  wire logic [awb_pkg::POS_W-1:0]  col,
  input  wire logic [awb_pkg::POS_W-1:0]  row_index,
  input  wire logic [7:0]                 pixel_in,
  input  wire logic                       truncate_coords,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      pixel_out,
  output logic                            inside_res
);
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int HXW = (XW > 1) ? XW - 1 : 1;
  localparam int HYW = (YW > 1) ? YW - 1 : 1;
  localparam int BW  = HXW + HYW;
  localparam int BANK_DEPTH = (1 << BW);
  localparam int MW  = awb_pkg::MAP_W;
  localparam int CB  = awb_pkg::COORD_BITS;
  localparam int SW  = FRAC_BITS + 1;
  localparam int DW  = (XW > YW ? XW : YW) + 2;

  // configuration registers
  logic signed [awb_pkg::COEF_W-1:0] coef_uu, coef_ur, coef_vc, coef_vr;
  logic signed [awb_pkg::OFFS_W-1:0] offset_u, offset_v;
  logic [awb_pkg::DIM_W-1:0] source_width, source_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_uu <= 17'sd4096; coef_ur <= '0; coef_vc <= '0; coef_vr <= 17'sd4096;
      offset_u <= '0; offset_v <= '0;
      source_width <= 10'd512; source_height <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        awb_pkg::REG_COEF_UU:  coef_uu <= cfg_data[awb_pkg::COEF_W-1:0];
        awb_pkg::REG_COEF_UR:  coef_ur <= cfg_data[awb_pkg::COEF_W-1:0];
        awb_pkg::REG_COEF_VC:  coef_vc <= cfg_data[awb_pkg::COEF_W-1:0];
        awb_pkg::REG_COEF_VR:  coef_vr <= cfg_data[awb_pkg::COEF_W-1:0];
        awb_pkg::REG_OFFSET_U: offset_u <= cfg_data;
        awb_pkg::REG_OFFSET_V: offset_v <= cfg_data;
        awb_pkg::REG_SRC_W:    source_width <= cfg_data[awb_pkg::DIM_W-1:0];
        awb_pkg::REG_SRC_H:    source_height <= cfg_data[awb_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions, saturated to the frame size
  logic [DW-1:0] eff_w, eff_h;
  always_comb begin
    eff_w = (DW'(source_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(source_width);
    eff_h = (DW'(source_height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(source_height);
  end

  // pipeline advance: whole pipe moves unless the output holds a result that is not taken
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // ---- stage 1: products ----
  logic v1, t1;
  logic signed [MW-1:0] puc, pur, pvc, pvr;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid && command == awb_pkg::CMD_REQUEST;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t1  <= truncate_coords;
      puc <= MW'(coef_uu * $signed({1'b0, col}));
      pur <= MW'(coef_ur * $signed({1'b0, row_index}));
      pvc <= MW'(coef_vc * $signed({1'b0, col}));
      pvr <= MW'(coef_vr * $signed({1'b0, row_index}));
    end
  end

  // write items ride along the pipe and commit at the read stage
  function automatic logic [awb_pkg::POS_W:0] POS_W_MW(input int n);
    POS_W_MW = (awb_pkg::POS_W + 1)'(n);
  endfunction
  logic wr_ok;
  assign wr_ok = in_valid && command == awb_pkg::CMD_WRITE &&
                 col < POS_W_MW(MAX_WIDTH) && row_index < POS_W_MW(MAX_HEIGHT);
  logic wv1, wv2;
  logic [1:0] wb1, wb2;
  logic [BW-1:0] wa1, wa2;
  logic [7:0] wd1, wd2;
  always_ff @(posedge clk) begin
    if (rst) begin
      wv1 <= 1'b0;
      wv2 <= 1'b0;
    end else if (adv) begin
      wv1 <= wr_ok;
      wv2 <= wv1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      wb1 <= {row_index[0], col[0]};
      wa1 <= {row_index[YW-1:1], col[XW-1:1]};
      wd1 <= pixel_in;
      wb2 <= wb1;
      wa2 <= wa1;
      wd2 <= wd1;
    end
  end

  // ---- stage 2: sums plus offsets, optional cut toward zero ----
  logic signed [MW-1:0] su, sv, cu, cv;
  always_comb begin
    su = puc + pur + MW'(offset_u);
    sv = pvc + pvr + MW'(offset_v);
    cu = su;
    cv = sv;
    if (t1) begin
      cu = su[MW-1] ? -((-su) & ~MW'((1 << CB) - 1)) : su & ~MW'((1 << CB) - 1);
      cv = sv[MW-1] ? -((-sv) & ~MW'((1 << CB) - 1)) : sv & ~MW'((1 << CB) - 1);
    end
  end
  logic v2;
  logic signed [MW-1:0] u2, w2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      u2 <= cu;
      w2 <= cv;
    end
  end

  // ---- stage 3: bounds, neighbour addresses, memory read ----
  logic [MW-CB-1:0] xi, yi;
  logic inside3;
  logic [XW-1:0] x0;
  logic [YW-1:0] y0;
  logic [XW:0] x1;
  logic [YW:0] y1;
  assign xi = u2[MW-1:CB];
  assign yi = w2[MW-1:CB];
  assign inside3 = !u2[MW-1] && !w2[MW-1] &&
                   (xi < (MW-CB)'(eff_w)) && (yi < (MW-CB)'(eff_h));
  assign x0 = xi[XW-1:0];
  assign y0 = yi[YW-1:0];
  assign x1 = {1'b0, x0} + 1'b1;
  assign y1 = {1'b0, y0} + 1'b1;

  // bank address for each parity: use the neighbour row/column of matching parity
  logic [XW-1:0] xe, xo;
  logic [YW-1:0] ye, yo;
  assign xe = x0[0] ? x1[XW-1:0] : x0;
  assign xo = x0[0] ? x0 : x1[XW-1:0];
  assign ye = y0[0] ? y1[YW-1:0] : y0;
  assign yo = y0[0] ? y0 : y1[YW-1:0];

  logic [BW-1:0] raddr [4];
  assign raddr[0] = {ye[YW-1:1], xe[XW-1:1]};
  assign raddr[1] = {ye[YW-1:1], xo[XW-1:1]};
  assign raddr[2] = {yo[YW-1:1], xe[XW-1:1]};
  assign raddr[3] = {yo[YW-1:1], xo[XW-1:1]};

  logic [7:0] rd [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    awb_bank #(.DEPTH(BANK_DEPTH), .AW(BW)) u_bank (
      .clk  (clk),
      .we   (adv && wv2 && wb2 == 2'(b)),
      .waddr(wa2),
      .wdata(wd2),
      .re   (adv),
      .raddr(raddr[b]),
      .rdata(rd[b])
    );
  end

  logic v3, in3, xp3, yp3, xe3, ye3;
  logic [FRAC_BITS-1:0] fx3, fy3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      in3 <= inside3;
      xp3 <= x0[0];
      yp3 <= y0[0];
      xe3 <= (DW'(x1) >= eff_w);
      ye3 <= (DW'(y1) >= eff_h);
      fx3 <= u2[CB-1 -: FRAC_BITS];
      fy3 <= w2[CB-1 -: FRAC_BITS];
    end
  end

  // ---- stage 4: select neighbours, horizontal weights ----
  logic [7:0] q00, q10, q01, q11;
  always_comb begin
    logic [7:0] e_top, o_top, e_bot, o_bot;
    e_top = yp3 ? rd[2] : rd[0];
    o_top = yp3 ? rd[3] : rd[1];
    e_bot = yp3 ? rd[0] : rd[2];
    o_bot = yp3 ? rd[1] : rd[3];
    q00 = xp3 ? o_top : e_top;
    q10 = xp3 ? e_top : o_top;
    q01 = xp3 ? o_bot : e_bot;
    q11 = xp3 ? e_bot : o_bot;
    if (xe3) begin q10 = '0; q11 = '0; end
    if (ye3) begin q01 = '0; q11 = '0; end
  end
  localparam int HW = 8 + SW;
  logic [SW-1:0] s_fx;
  assign s_fx = SW'(1 << FRAC_BITS) - SW'(fx3);
  logic v4, in4;
  logic [HW:0] top4, bot4;
  logic [FRAC_BITS-1:0] fy4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      in4  <= in3;
      fy4  <= fy3;
      top4 <= (HW+1)'(q00 * s_fx) + (HW+1)'(q10 * fx3);
      bot4 <= (HW+1)'(q01 * s_fx) + (HW+1)'(q11 * fx3);
    end
  end

  // ---- stage 5: vertical weights ----
  localparam int AW2 = HW + SW + 1;
  logic [SW-1:0] s_fy;
  assign s_fy = SW'(1 << FRAC_BITS) - SW'(fy4);
  logic v5, in5;
  logic [AW2-1:0] pt5, pb5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      in5 <= in4;
      pt5 <= AW2'(top4 * s_fy);
      pb5 <= AW2'(bot4 * fy4);
    end
  end

  // ---- stage 6: final sum into the output register ----
  logic [AW2-1:0] acc;
  assign acc = pt5 + pb5;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v5;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      inside_res <= in5;
      pixel_out  <= in5 ? acc[2*FRAC_BITS +: 8] : 8'd0;
    end
  end
endmodule
`default_nettype wire
